// ===== sv/ocv_pkg.sv =====
// ----------------------------------------------------------------------------
// ocv_pkg
// Shared widths, constants, the queue entry type and the Morton interleave
// for the octree cell cover emitter.
// ----------------------------------------------------------------------------
package ocv_pkg;

  localparam int CRD_W          = 10;
  localparam int ID_W           = 32;
  localparam int CELL_W         = 31;
  localparam int TLV_W          = 4;
  localparam int GL_W           = 4;
  localparam int MORTON_W       = 3 * CRD_W;
  localparam int SHF_W          = $clog2(CRD_W + 1);
  localparam int Q_DEPTH        = 2;
  localparam int OCV_MAX_LEVELS = 10;
  localparam logic [GL_W-1:0] GL_RESET = GL_W'(10);

  // One classified object, ready for cell enumeration
  typedef struct packed {
    logic                  err;
    logic [CRD_W-1:0]      lo_x;
    logic [CRD_W-1:0]      lo_y;
    logic [CRD_W-1:0]      lo_z;
    logic                  span_x;
    logic                  span_y;
    logic                  span_z;
    logic [CELL_W-1:0]     base;
    logic [TLV_W-1:0]      tree_level;
    logic [ID_W-1:0]       object_id;
  } ocv_entry_t;

  // Bit 3i is x bit i, bit 3i+1 is y bit i, bit 3i+2 is z bit i
  function automatic logic [MORTON_W-1:0] interleave3(input logic [CRD_W-1:0] x,
                                                      input logic [CRD_W-1:0] y,
                                                      input logic [CRD_W-1:0] z);
    logic [MORTON_W-1:0] code;
    code = '0;
    for (int i = 0; i < CRD_W; i++) begin
      code[3*i]     = x[i];
      code[3*i + 1] = y[i];
      code[3*i + 2] = z[i];
    end
    return code;
  endfunction

endpackage

// ===== sv/ocv_ifs.sv =====
// ----------------------------------------------------------------------------
// ocv channel interfaces
// Valid/ready channels for boxes in, cell results out and the level register.
// ----------------------------------------------------------------------------
interface ocv_in_if import ocv_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CRD_W-1:0] lo_x;
  logic [CRD_W-1:0] lo_y;
  logic [CRD_W-1:0] lo_z;
  logic [CRD_W-1:0] hi_x;
  logic [CRD_W-1:0] hi_y;
  logic [CRD_W-1:0] hi_z;
  logic [ID_W-1:0]  object_id;

  modport source(output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, object_id,
                 input ready);
  modport sink(input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, object_id,
               output ready);
endinterface

interface ocv_out_if import ocv_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_index;
  logic [ID_W-1:0]   object_id_out;
  logic [TLV_W-1:0]  tree_level;
  logic              last_cell;
  logic              out_of_grid;

  modport source(output valid, cell_index, object_id_out, tree_level, last_cell,
                 out_of_grid, input ready);
  modport sink(input valid, cell_index, object_id_out, tree_level, last_cell,
               out_of_grid, output ready);
endinterface

interface ocv_cfg_if import ocv_pkg::*;;
  logic            valid;
  logic            ready;
  logic [GL_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== sv/ocv_front.sv =====
// ----------------------------------------------------------------------------
// ocv_front
// Holds one box, range checks it, finds the coarsening shift and the level,
// queues an entry (none for an in-range empty box). Owns the level register.
// ----------------------------------------------------------------------------
module ocv_front import ocv_pkg::*; #(
  parameter int MAX_LEVELS = OCV_MAX_LEVELS
) (
  input  logic       clk,
  input  logic       rst_n,
  ocv_in_if.sink     in_ch,
  ocv_cfg_if.sink    cfg_ch,
  output logic       q_push,
  output ocv_entry_t q_data,
  input  logic       q_ready
);

  localparam int LVL_W = $clog2(MAX_LEVELS + 1);
  localparam int BASE_TERMS = (CELL_W + 2) / 3;

  logic [GL_W-1:0]  grid_levels_r, grid_levels_nxt;
  logic             hold_valid_r, hold_valid_nxt;
  logic [CRD_W-1:0] lo_r [3];
  logic [CRD_W-1:0] hi_r [3];
  logic [ID_W-1:0]  id_r;

  logic [LVL_W-1:0] lvl;
  logic [LVL_W-1:0] level;
  logic             oor;
  logic             empty;
  logic             drop;
  logic             advance;
  logic [CRD_W:0]   ok;
  logic [SHF_W-1:0] shift;
  logic [CRD_W-1:0] diff;
  logic [CRD_W-1:0] lo_s [3];
  logic [CRD_W-1:0] hi_s [3];
  logic [CELL_W-1:0] base;

  always_comb begin
    if (int'(grid_levels_r) > MAX_LEVELS) begin
      lvl = LVL_W'(MAX_LEVELS);
    end else begin
      lvl = LVL_W'(grid_levels_r);
    end

    oor   = 1'b0;
    empty = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (((lo_r[a] >> lvl) != '0) || ((hi_r[a] >> lvl) != '0)) begin
        oor = 1'b1;
      end
      if (lo_r[a] > hi_r[a]) begin
        empty = 1'b1;
      end
    end

    // every axis spans at most two cells at this shift
    for (int s = 0; s <= CRD_W; s++) begin
      ok[s] = 1'b1;
      for (int a = 0; a < 3; a++) begin
        diff = (hi_r[a] >> s) - (lo_r[a] >> s);
        if (diff > CRD_W'(1)) begin
          ok[s] = 1'b0;
        end
      end
    end

    // smallest passing shift wins
    shift = SHF_W'(CRD_W);
    for (int s = CRD_W; s >= 0; s--) begin
      if (ok[s]) begin
        shift = SHF_W'(s);
      end
    end

    level = lvl - LVL_W'(shift);

    // (8^level - 1) / 7 has bit 3i set for every i below level
    base = '0;
    for (int i = 0; i < BASE_TERMS; i++) begin
      base[3*i] = (int'(level) > i);
    end

    for (int a = 0; a < 3; a++) begin
      lo_s[a] = lo_r[a] >> shift;
      hi_s[a] = hi_r[a] >> shift;
    end
  end

  always_comb begin
    q_data = '0;
    q_data.object_id = id_r;
    if (oor) begin
      q_data.err = 1'b1;
    end else begin
      q_data.lo_x       = lo_s[0];
      q_data.lo_y       = lo_s[1];
      q_data.lo_z       = lo_s[2];
      q_data.span_x     = (hi_s[0] != lo_s[0]);
      q_data.span_y     = (hi_s[1] != lo_s[1]);
      q_data.span_z     = (hi_s[2] != lo_s[2]);
      q_data.base       = base;
      q_data.tree_level = TLV_W'(level);
    end
  end

  assign drop         = !oor && empty;
  assign q_push       = hold_valid_r && !drop && q_ready;
  assign advance      = hold_valid_r && (drop || q_ready);
  assign in_ch.ready  = !hold_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end
    grid_levels_nxt = grid_levels_r;
    if (cfg_ch.valid) begin
      grid_levels_nxt = cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r  <= 1'b0;
      grid_levels_r <= GL_RESET;
    end else begin
      hold_valid_r  <= hold_valid_nxt;
      grid_levels_r <= grid_levels_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      lo_r[0] <= in_ch.lo_x;
      lo_r[1] <= in_ch.lo_y;
      lo_r[2] <= in_ch.lo_z;
      hi_r[0] <= in_ch.hi_x;
      hi_r[1] <= in_ch.hi_y;
      hi_r[2] <= in_ch.hi_z;
      id_r    <= in_ch.object_id;
    end
  end

endmodule

// ===== sv/ocv_queue.sv =====
// ----------------------------------------------------------------------------
// ocv_queue
// Short FIFO of classified entries between the front and the back.
// Depth is a power of two so the pointers wrap on their own.
// ----------------------------------------------------------------------------
module ocv_queue import ocv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ocv_entry_t push_data,
  output logic       push_ready,
  output logic       pop_valid,
  output ocv_entry_t pop_data,
  input  logic       pop
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  ocv_entry_t       mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != CNT_W'(Q_DEPTH))
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue pop while empty");
  a_cnt_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("queue count lost a push");
`endif

endmodule

// ===== sv/ocv_back.sv =====
// ----------------------------------------------------------------------------
// ocv_back
// Pops a classified entry and walks its covered cells in z, y, x order,
// one result per cycle unless out_ch stalls, into the output register.
// ----------------------------------------------------------------------------
module ocv_back import ocv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  ocv_entry_t q_data,
  output logic       q_pop,
  ocv_out_if.source  out_ch
);

  logic              cur_valid_r, cur_valid_nxt;
  ocv_entry_t        cur_r;
  logic              cx_r, cx_nxt;
  logic              cy_r, cy_nxt;
  logic              cz_r, cz_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0] cell_r;
  logic [ID_W-1:0]   id_r;
  logic [TLV_W-1:0]  lvl_r;
  logic              last_r;
  logic              err_r;

  logic              emit;
  logic              is_last;
  logic [CRD_W-1:0]  x, y, z;
  logic [CELL_W-1:0] cell_idx;

  assign emit    = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign is_last = cur_r.err ||
                   ((cx_r == cur_r.span_x) && (cy_r == cur_r.span_y) &&
                    (cz_r == cur_r.span_z));
  assign q_pop   = q_valid && (!cur_valid_r || (emit && is_last));

  always_comb begin
    x        = cur_r.lo_x + CRD_W'(cx_r);
    y        = cur_r.lo_y + CRD_W'(cy_r);
    z        = cur_r.lo_z + CRD_W'(cz_r);
    cell_idx = cur_r.err ? '0 : cur_r.base + CELL_W'(interleave3(x, y, z));
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    cz_nxt = cz_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cx_nxt = 1'b0;
      cy_nxt = 1'b0;
      cz_nxt = 1'b0;
    end else if (emit && is_last) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      // x fastest, then y, then z
      if (cx_r != cur_r.span_x) begin
        cx_nxt = 1'b1;
      end else begin
        cx_nxt = 1'b0;
        if (cy_r != cur_r.span_y) begin
          cy_nxt = 1'b1;
        end else begin
          cy_nxt = 1'b0;
          cz_nxt = 1'b1;
        end
      end
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      cx_r        <= 1'b0;
      cy_r        <= 1'b0;
      cz_r        <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      cz_r        <= cz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (emit) begin
      cell_r <= cell_idx;
      id_r   <= cur_r.object_id;
      lvl_r  <= cur_r.tree_level;
      last_r <= is_last;
      err_r  <= cur_r.err;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_index    = cell_r;
  assign out_ch.object_id_out = id_r;
  assign out_ch.tree_level    = lvl_r;
  assign out_ch.last_cell     = last_r;
  assign out_ch.out_of_grid   = err_r;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r) |-> last_r)
    else $error("error result not marked last");
  a_cnt_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> ((cx_r && !cur_r.span_x) || (cy_r && !cur_r.span_y) ||
                     (cz_r && !cur_r.span_z)) == 1'b0)
    else $error("cell counter beyond span");
  a_drain_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last && !q_pop) |=> !cur_valid_r)
    else $error("entry kept after last cell");
`endif

endmodule

// ===== sv/octree_cell_cover_emitter_core.sv =====
// ----------------------------------------------------------------------------
// octree_cell_cover_emitter_core
// Turns an object's vertex bounding box into the octree cells it covers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one box (lo/hi per axis) and object id per transaction.
//   out_ch : one covered cell per transaction, z/y/x order, last_cell on the
//            final one; an out-of-grid box gives a single out_of_grid result,
//            an empty box gives none.
//   cfg_ch : writes grid_levels; always ready, write only while idle.
// Path: a box is held in the front register for classification, passes the
//   two-entry queue, is loaded into the back end's entry register, and its
//   results then leave through the output register.
// Throughput: the back end emits one result per cycle while out_ch is ready,
//   one per covered cell, up to 8 per box (one for an error result); the
//   front keeps classifying while the back end works, up to the queue depth.
// Reset: clears all valid state and sets grid_levels to 10; no clearing pass.
// Stall: when out_ch is not ready the output register holds, the back end
//   waits, the queue fills and in_ch.ready drops once the front is blocked.
// ----------------------------------------------------------------------------
module octree_cell_cover_emitter_core import ocv_pkg::*; #(
  parameter int MAX_LEVELS = OCV_MAX_LEVELS
) (
  input  logic      clk,
  input  logic      rst_n,
  ocv_in_if.sink    in_ch,
  ocv_out_if.source out_ch,
  ocv_cfg_if.sink   cfg_ch
);

  logic       q_push;
  logic       q_push_ready;
  logic       q_pop_valid;
  logic       q_pop;
  ocv_entry_t q_push_data;
  ocv_entry_t q_pop_data;

  ocv_front #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_push  (q_push),
    .q_data  (q_push_data),
    .q_ready (q_push_ready)
  );

  ocv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_data   (q_pop_data),
    .pop        (q_pop)
  );

  ocv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_pop_valid),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
